[hdl/assert_macros.svh]
// Assertion macros used by the top level of the peak meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SWPM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sliding_window_peak_meter: assertion failed");

// Same-cycle implication.
`define SWPM_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sliding_window_peak_meter: assertion failed");

// Next-cycle implication.
`define SWPM_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sliding_window_peak_meter: assertion failed");

`endif

[hdl/swpm_pkg.sv]
// Package with sizes, types and helper functions of the peak meter.
`timescale 1ns / 1ps

package swpm_pkg;

    localparam int RING_DEPTH   = 16384;
    localparam int RING_AW      = $clog2(RING_DEPTH);
    localparam int LEN_W        = RING_AW + 1;
    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = 4;
    localparam int FRAMES_W     = 15;
    localparam int SAMPLE_W     = 16;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SAMPLE_MODE   = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] CFG_WINDOW_FRAMES = 2'd2;

    typedef logic [RING_AW-1:0]         t_ring_addr;
    typedef logic [LEN_W-1:0]           t_len;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Write port of the sample ring.
    typedef struct packed {
        logic       en;
        t_ring_addr addr;
        t_sample    data;
    } t_ring_wr;

    // Frames that fit in the ring for a given channel count.
    function automatic t_len ring_limit(input logic [CNT_W-1:0] cc);
        t_len lim;
        case (cc)
            4'd1:    lim = LEN_W'(RING_DEPTH / 1);
            4'd2:    lim = LEN_W'(RING_DEPTH / 2);
            4'd3:    lim = LEN_W'(RING_DEPTH / 3);
            4'd4:    lim = LEN_W'(RING_DEPTH / 4);
            4'd5:    lim = LEN_W'(RING_DEPTH / 5);
            4'd6:    lim = LEN_W'(RING_DEPTH / 6);
            4'd7:    lim = LEN_W'(RING_DEPTH / 7);
            default: lim = LEN_W'(RING_DEPTH / MAX_CHANNELS);
        endcase
        return lim;
    endfunction

    // Raw bits to a signed sample: 16-bit two's complement, or offset 8-bit.
    function automatic t_sample convert_sample(input logic mode,
                                               input logic [SAMPLE_W-1:0] raw);
        t_sample v;
        if (mode) begin
            v = SAMPLE_W'($signed({~raw[7], raw[6:0]}));
        end else begin
            v = $signed(raw);
        end
        return v;
    endfunction

endpackage

[hdl/sliding_window_peak_meter.sv]
// Top level of the sliding-window peak meter: sequencer, extrema and ports.
//
//  Channel   Direction  Fields (lowest bit first)
//  --------  ---------  ----------------------------------------------
//  s_axis    in         tdata: raw_sample[15:0]
//                       tuser: query_channel[2:0], clear[3]
//  m_axis    out        tdata: peak[15:0]
//  cfg       in         i_cfg_index 0..2, i_cfg_data[14:0]
//
// A sample transaction with a fresh (not stale) queried channel runs through
// accept, ring address fix-up and read, evict and write, query and result. A
// stale channel adds a rescan that reads one ring entry a cycle through the
// single ring read port. A clear transaction sweeps all 16384 ring entries, one
// entry a cycle, and then answers its query with a rescan if the queried
// channel is within the channel count. After reset the same sweep runs before
// s_axis_tready first rises; configuration writes are taken at all times. A
// stalled m_axis holds the result register and the sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sliding_window_peak_meter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Sample stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // raw_sample[15:0]
    input  logic [3:0]  s_axis_tuser,   // query_channel[2:0], clear[3]
    // Peak results.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // peak[15:0]
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam int RAW = swpm_pkg::RING_AW;
    localparam int LW  = swpm_pkg::LEN_W;
    localparam int CW  = swpm_pkg::CH_W;
    localparam int NW  = swpm_pkg::CNT_W;
    localparam int NCH = swpm_pkg::MAX_CHANNELS;
    localparam int SW  = swpm_pkg::SAMPLE_W;

    // Sequencer states.
    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_EVICT = 3'd3;
    localparam logic [2:0] S_QUERY = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Configuration registers.
    logic                         r_mode;
    logic [NW-1:0]                r_chan_cnt;
    logic [swpm_pkg::FRAMES_W-1:0] r_win_frames;

    // Per-transaction context.
    logic [NW-1:0]        r_cc;
    swpm_pkg::t_len       r_len;
    logic [CW-1:0]        r_query;
    swpm_pkg::t_sample    r_sample;
    swpm_pkg::t_ring_addr r_idx;

    // Write position.
    swpm_pkg::t_ring_addr r_fb;
    logic [CW-1:0]        r_cursor;

    // Per-channel extrema and stale marks.
    swpm_pkg::t_sample r_max [NCH];
    swpm_pkg::t_sample r_min [NCH];
    logic [NCH-1:0]    r_stale;

    // Working extrema of the queried channel and scan control.
    swpm_pkg::t_sample    r_acc_min;
    swpm_pkg::t_sample    r_acc_max;
    logic                 r_wb;
    logic                 r_first;
    logic                 r_pend;
    swpm_pkg::t_len       r_scan_addr;
    swpm_pkg::t_ring_addr r_clr_addr;
    logic                 r_boot;

    // Result register.
    logic          r_out_valid;
    logic [SW-1:0] r_out_peak;

    // Ring port.
    swpm_pkg::t_ring_wr   ring_wr;
    swpm_pkg::t_ring_addr ring_rd_addr;
    swpm_pkg::t_sample    ring_rd_data;

    swpm_ring u_ring (
        .i_clk     (i_clk),
        .i_wr      (ring_wr),
        .i_rd_addr (ring_rd_addr),
        .o_rd_data (ring_rd_data)
    );

    // Handshakes.
    logic in_fire;
    logic out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_peak;
    assign o_cfg_ready   = 1'b1;

    // Effective channel count and window length, taken at accept time.
    logic [NW-1:0]                 cc_use;
    logic [swpm_pkg::FRAMES_W-1:0] frames_req;
    swpm_pkg::t_len                frames_lim;
    swpm_pkg::t_len                frames_use;
    logic [LW+NW-1:0]              len_prod;

    always_comb begin
        if (r_chan_cnt == '0) begin
            cc_use = NW'(1);
        end else if (r_chan_cnt > NW'(NCH)) begin
            cc_use = NW'(NCH);
        end else begin
            cc_use = r_chan_cnt;
        end
        frames_req = (r_win_frames == '0) ? swpm_pkg::FRAMES_W'(1) : r_win_frames;
        frames_lim = swpm_pkg::ring_limit(cc_use);
        frames_use = (LW'(frames_req) > frames_lim) ? frames_lim : LW'(frames_req);
        len_prod   = frames_use * cc_use;
    end

    // Position fix-up before the write: a cursor or frame off the window
    // restarts at the beginning.
    logic [CW-1:0]        cur_fix;
    logic [RAW+1:0]       fb_sum;
    swpm_pkg::t_ring_addr fb_fix;
    swpm_pkg::t_ring_addr prep_idx;

    always_comb begin
        cur_fix  = (NW'(r_cursor) >= r_cc) ? '0 : r_cursor;
        fb_sum   = (RAW+2)'(r_fb) + (RAW+2)'(r_cc);
        fb_fix   = (fb_sum > (RAW+2)'(r_len)) ? '0 : r_fb;
        prep_idx = fb_fix + RAW'(cur_fix);
    end

    // Extrema table read: one address, the write cursor during eviction and
    // the queried channel otherwise.
    logic [CW-1:0]     ext_idx;
    swpm_pkg::t_sample ext_max;
    swpm_pkg::t_sample ext_min;

    assign ext_idx = (r_state == S_EVICT) ? r_cursor : r_query;
    assign ext_max = r_max[ext_idx];
    assign ext_min = r_min[ext_idx];

    // Eviction: stale check, widened extrema and the next write position.
    logic                 evict_stale;
    logic [NW-1:0]        cur_next;
    logic                 cur_wrap;
    logic [RAW+1:0]       fb_adv;
    logic [RAW+1:0]       fb_adv_end;
    swpm_pkg::t_ring_addr fb_after;
    logic [CW-1:0]        cursor_after;

    always_comb begin
        evict_stale  = (ring_rd_data == ext_max) || (ring_rd_data == ext_min);
        cur_next     = NW'(r_cursor) + NW'(1);
        cur_wrap     = (cur_next >= r_cc);
        fb_adv       = (RAW+2)'(r_fb) + (RAW+2)'(r_cc);
        fb_adv_end   = fb_adv + (RAW+2)'(r_cc);
        cursor_after = cur_wrap ? '0 : cur_next[CW-1:0];
        if (!cur_wrap) begin
            fb_after = r_fb;
        end else if (fb_adv_end > (RAW+2)'(r_len)) begin
            fb_after = '0;
        end else begin
            fb_after = fb_adv[RAW-1:0];
        end
    end

    // Rescan stepping: one address issued a cycle, its data folded in the next cycle.
    logic           scan_issue;
    swpm_pkg::t_len scan_next;

    assign scan_issue = (r_scan_addr < r_len);
    assign scan_next  = r_scan_addr + LW'(r_cc);

    // Peak magnitude of the working extrema.
    logic signed [SW:0] min_ext;
    logic signed [SW:0] max_ext;
    logic signed [SW:0] min_mag;
    logic signed [SW:0] peak_wide;

    always_comb begin
        min_ext   = (SW+1)'(r_acc_min);
        max_ext   = (SW+1)'(r_acc_max);
        min_mag   = (min_ext < 0) ? -min_ext : min_ext;
        peak_wide = (max_ext > min_mag) ? max_ext : min_mag;
    end

    // Ring port control.
    always_comb begin
        ring_rd_addr = (r_state == S_PREP) ? prep_idx : r_scan_addr[RAW-1:0];
        ring_wr.en   = (r_state == S_CLR) || (r_state == S_EVICT);
        ring_wr.addr = (r_state == S_CLR) ? r_clr_addr : r_idx;
        ring_wr.data = (r_state == S_CLR) ? '0 : r_sample;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR: begin
                if (&r_clr_addr) begin
                    n_state = r_boot ? S_IDLE : S_QUERY;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_state = s_axis_tuser[3] ? S_CLR : S_PREP;
                end
            end
            S_PREP:  n_state = S_EVICT;
            S_EVICT: n_state = S_QUERY;
            S_QUERY: begin
                if (NW'(r_query) >= r_cc) begin
                    n_state = S_DONE;
                end else if (r_stale[r_query]) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (!scan_issue && !r_pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_chan_cnt   <= NW'(2);
            r_win_frames <= swpm_pkg::FRAMES_W'(4800);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                swpm_pkg::CFG_SAMPLE_MODE:   r_mode       <= i_cfg_data[0];
                swpm_pkg::CFG_CHANNEL_COUNT: r_chan_cnt   <= i_cfg_data[NW-1:0];
                swpm_pkg::CFG_WINDOW_FRAMES: r_win_frames <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Transaction context, captured on accept.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cc     <= cc_use;
            r_len    <= len_prod[LW-1:0];
            r_query  <= s_axis_tuser[CW-1:0];
            r_sample <= swpm_pkg::convert_sample(r_mode, s_axis_tdata);
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_boot      <= 1'b1;
            r_clr_addr  <= '0;
            r_fb        <= '0;
            r_cursor    <= '0;
            r_stale     <= '1;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_first     <= 1'b0;
            r_wb        <= 1'b0;
            for (int i = 0; i < NCH; i++) begin
                r_max[i] <= '0;
                r_min[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            // A result leaving while the next one is formed stays valid.
            if (m_axis_tvalid && m_axis_tready && !((r_state == S_DONE) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + RAW'(1);
                end
                S_IDLE: begin
                    if (in_fire && s_axis_tuser[3]) begin
                        // Clear: extrema zeroed, every channel stale, ring swept.
                        r_boot     <= 1'b0;
                        r_clr_addr <= '0;
                        r_fb       <= '0;
                        r_cursor   <= '0;
                        r_stale    <= '1;
                        for (int i = 0; i < NCH; i++) begin
                            r_max[i] <= '0;
                            r_min[i] <= '0;
                        end
                    end
                end
                S_PREP: begin
                    r_cursor <= cur_fix;
                    r_fb     <= fb_fix;
                    r_idx    <= prep_idx;
                end
                S_EVICT: begin
                    if (evict_stale) begin
                        r_stale[r_cursor] <= 1'b1;
                    end
                    if (r_sample > ext_max) begin
                        r_max[r_cursor] <= r_sample;
                    end
                    if (r_sample < ext_min) begin
                        r_min[r_cursor] <= r_sample;
                    end
                    r_cursor <= cursor_after;
                    r_fb     <= fb_after;
                end
                S_QUERY: begin
                    r_scan_addr <= LW'(r_query);
                    r_pend      <= 1'b0;
                    r_first     <= 1'b1;
                    if (NW'(r_query) >= r_cc) begin
                        r_acc_min <= '0;
                        r_acc_max <= '0;
                        r_wb      <= 1'b0;
                    end else begin
                        r_acc_min <= ext_min;
                        r_acc_max <= ext_max;
                        r_wb      <= 1'b1;
                    end
                end
                S_SCAN: begin
                    r_pend <= scan_issue;
                    if (scan_issue) begin
                        r_scan_addr <= scan_next;
                    end
                    if (r_pend) begin
                        r_first <= 1'b0;
                        if (r_first || ring_rd_data < r_acc_min) begin
                            r_acc_min <= ring_rd_data;
                        end
                        if (r_first || ring_rd_data > r_acc_max) begin
                            r_acc_max <= ring_rd_data;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_peak  <= peak_wide[SW-1:0];
                        if (r_wb) begin
                            r_min[r_query]   <= r_acc_min;
                            r_max[r_query]   <= r_acc_max;
                            r_stale[r_query] <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Terms used by the checks below.
    logic evict_pos_ok;
    logic wb_fire;

    assign evict_pos_ok = (NW'(r_cursor) < r_cc) && (fb_sum <= (RAW+2)'(r_len));
    assign wb_fire      = (r_state == S_DONE) && out_free && r_wb;

    // The write position has been brought inside the window before eviction.
    `SWPM_ASSERT_IMP(a_evict_in_window, i_clk, i_rst_n, (r_state == S_EVICT), evict_pos_ok)

    // The working extrema never cross when a result is formed.
    `SWPM_ASSERT_IMP(a_acc_ordered, i_clk, i_rst_n, (r_state == S_DONE), (r_acc_min <= r_acc_max))

    // A queried channel within the count is fresh right after its result is registered.
    `SWPM_ASSERT_NXT(a_query_fresh, i_clk, i_rst_n, wb_fire, (!r_stale[$past(r_query)]))

endmodule

[hdl/swpm_ring.sv]
// Single-port-write, single-port-read sample ring with registered read data.
`timescale 1ns / 1ps

module swpm_ring (
    input  logic                i_clk,
    input  swpm_pkg::t_ring_wr  i_wr,
    input  swpm_pkg::t_ring_addr i_rd_addr,
    output swpm_pkg::t_sample   o_rd_data
);

    swpm_pkg::t_sample r_mem [swpm_pkg::RING_DEPTH];
    swpm_pkg::t_sample r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
